FILE: hw/rtl/mqchi2_pkg.sv
// Shared constants, request/result types and control structs for the chi-square engine.
package mqchi2_pkg;

   localparam int MAX_PARAMS = 64;
   localparam int PIDX_W     = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
   localparam int MAT_AW     = 2 * PIDX_W;
   localparam int MAT_DEPTH  = 2 ** MAT_AW;
   localparam int PAR_DEPTH  = 2 ** PIDX_W;

   localparam int VAL_W       = 32;
   localparam int DELTA_W     = VAL_W + 1;
   localparam int MUL_W       = DELTA_W + 1;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int RACC_W      = 2 * VAL_W + 2 + PIDX_W;
   localparam int SUM_W       = 128;
   localparam int CHI_W       = 64;
   localparam int FRAC_SHIFT  = 16;
   localparam int CHUNK_W     = 32;
   localparam int NUM_CHUNKS  = 3;
   localparam int CHUNK_IDX_W = 2;
   localparam int FIN_WAIT    = 2;
   localparam int WAIT_W      = 2;

   localparam int NUMP_W     = 7;
   localparam int NUMP_RESET = 64;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   localparam logic [CHI_W-1:0] CHI_MIN = {1'b1, {(CHI_W-1){1'b0}}};
   localparam logic [CHI_W-1:0] CHI_MAX = {1'b0, {(CHI_W-1){1'b1}}};

   typedef enum logic [1:0] {
      OP_MATRIX  = 2'd0,
      OP_PARAM   = 2'd1,
      OP_COMPUTE = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SET_ENABLED = 1'b0,
      CSR_NUM_PARAMS  = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_type             op;
      logic [5:0]         row;
      logic [5:0]         col;
      logic signed [31:0] entry_value;
      logic signed [31:0] prior;
      logic               param_on;
   } req_type;

   typedef struct packed {
      logic signed [63:0] chi2;
      logic               status;
   } rsp_type;

   typedef struct packed {
      logic                   scan_vld;
      logic                   rowmul_vld;
      logic                   first;
      logic                   mask;
      logic [CHUNK_IDX_W-1:0] k;
      logic                   clear_total;
      logic                   emit;
      logic                   emit_zero;
   } mac_ctl_type;

   typedef struct packed {
      logic [PIDX_W-1:0] row;
      logic [PIDX_W-1:0] col;
   } rd_idx_type;

endpackage

FILE: hw/rtl/masked_quadratic_form_chi2_top.sv
// Top level of the masked quadratic-form chi-square engine.
// Load requests (matrix entry, parameter) give no result and keep busy low.
// Compute walks n rows, n = active dimension, and then strobes its result: per row, one matrix
// entry per cycle, then a gap and a row product in three chunks; busy holds meanwhile.
// Disabled set, unloaded matrix or n of zero answer in the cycle after accept; the receiver
// cannot stall. Synchronous reset clears control, enable bits and loaded flag; memories keep data.
module masked_quadratic_form_chi2_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  mqchi2_pkg::req_type                  req_item,
   output logic                                 rsp_valid,
   output mqchi2_pkg::rsp_type                  rsp_item,
   input  logic                                 csr_we,
   input  logic [mqchi2_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mqchi2_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic                                  set_enabled_ff;
   logic [mqchi2_pkg::NUMP_W-1:0]         num_params_ff;
   logic                                  matrix_loaded_ff;
   logic [mqchi2_pkg::MAX_PARAMS-1:0]     enable_ff;
   logic                                  accept, row_ok, col_ok, mat_we, par_we;
   logic [mqchi2_pkg::MAT_AW-1:0]         mat_wr_addr, mat_rd_addr;
   logic signed [mqchi2_pkg::DELTA_W-1:0] delta_wr, d_row, d_col;
   logic signed [mqchi2_pkg::VAL_W-1:0]   m_entry;
   logic                                  rsp_status;
   logic signed [mqchi2_pkg::CHI_W-1:0]   chi2;
   mqchi2_pkg::mac_ctl_type               ctl;
   mqchi2_pkg::rd_idx_type                rd_idx;

   assign accept      = start && !busy;
   assign row_ok      = int'(req_item.row) < mqchi2_pkg::MAX_PARAMS;
   assign col_ok      = int'(req_item.col) < mqchi2_pkg::MAX_PARAMS;
   assign mat_we      = accept && req_item.op == mqchi2_pkg::OP_MATRIX && row_ok && col_ok;
   assign par_we      = accept && req_item.op == mqchi2_pkg::OP_PARAM && row_ok;
   assign mat_wr_addr = {mqchi2_pkg::PIDX_W'(req_item.row), mqchi2_pkg::PIDX_W'(req_item.col)};
   assign mat_rd_addr = {rd_idx.row, rd_idx.col};
   assign delta_wr    = mqchi2_pkg::DELTA_W'(req_item.entry_value)
                      - mqchi2_pkg::DELTA_W'(req_item.prior);

   always_ff @(posedge clock) begin
      if (reset) begin
         set_enabled_ff   <= 1'b1;
         num_params_ff    <= mqchi2_pkg::NUMP_W'(mqchi2_pkg::NUMP_RESET);
         matrix_loaded_ff <= 1'b0;
         enable_ff        <= '0;
      end else begin
         if (csr_we) begin
            unique case (mqchi2_pkg::csr_index_type'(csr_index))
               mqchi2_pkg::CSR_SET_ENABLED: set_enabled_ff <= csr_wdata[0];
               mqchi2_pkg::CSR_NUM_PARAMS:  num_params_ff  <= csr_wdata[mqchi2_pkg::NUMP_W-1:0];
            endcase
         end
         if (mat_we) begin
            matrix_loaded_ff <= 1'b1;
         end
         if (par_we) begin
            enable_ff[mqchi2_pkg::PIDX_W'(req_item.row)] <= req_item.param_on;
         end
      end
   end

   mqchi2_ram #(
      .WIDTH (mqchi2_pkg::VAL_W),
      .DEPTH (mqchi2_pkg::MAT_DEPTH)
   ) u_mat_ram (
      .clock   (clock),
      .wr_en   (mat_we),
      .wr_addr (mat_wr_addr),
      .wr_data (req_item.entry_value),
      .rd_addr (mat_rd_addr),
      .rd_data (m_entry)
   );

   mqchi2_ram #(
      .WIDTH (mqchi2_pkg::DELTA_W),
      .DEPTH (mqchi2_pkg::PAR_DEPTH)
   ) u_row_delta_ram (
      .clock   (clock),
      .wr_en   (par_we),
      .wr_addr (mqchi2_pkg::PIDX_W'(req_item.row)),
      .wr_data (delta_wr),
      .rd_addr (rd_idx.row),
      .rd_data (d_row)
   );

   mqchi2_ram #(
      .WIDTH (mqchi2_pkg::DELTA_W),
      .DEPTH (mqchi2_pkg::PAR_DEPTH)
   ) u_col_delta_ram (
      .clock   (clock),
      .wr_en   (par_we),
      .wr_addr (mqchi2_pkg::PIDX_W'(req_item.row)),
      .wr_data (delta_wr),
      .rd_addr (rd_idx.col),
      .rd_data (d_col)
   );

   mqchi2_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_op        (req_item.op),
      .set_enabled   (set_enabled_ff),
      .num_params    (num_params_ff),
      .matrix_loaded (matrix_loaded_ff),
      .enable_vec    (enable_ff),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .ctl           (ctl),
      .rd_idx        (rd_idx)
   );

   mqchi2_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .d_row   (d_row),
      .d_col   (d_col),
      .m_entry (m_entry),
      .chi2    (chi2)
   );

   assign rsp_item.chi2   = chi2;
   assign rsp_item.status = rsp_status;

endmodule

FILE: hw/rtl/mqchi2_ram.sv
// Generic simple dual-port RAM with registered read.
module mqchi2_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/mqchi2_mac.sv
// Shared multiplier with row and total accumulators and Q32.32 saturation.
module mqchi2_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  mqchi2_pkg::mac_ctl_type             ctl,
   input  logic signed [mqchi2_pkg::DELTA_W-1:0] d_row,
   input  logic signed [mqchi2_pkg::DELTA_W-1:0] d_col,
   input  logic signed [mqchi2_pkg::VAL_W-1:0]   m_entry,
   output logic signed [mqchi2_pkg::CHI_W-1:0]   chi2
);

   logic                                 s1_scan_ff, s1_rowmul_ff, s1_first_ff, s1_mask_ff;
   logic [mqchi2_pkg::CHUNK_IDX_W-1:0]   s1_k_ff;
   logic                                 p_scan_ff, p_rowmul_ff, p_first_ff, p_mask_ff;
   logic [mqchi2_pkg::CHUNK_IDX_W-1:0]   p_k_ff;
   logic signed [mqchi2_pkg::MUL_W-1:0]  op_a, op_b;
   logic signed [mqchi2_pkg::PROD_W-1:0] prod_in, prod_ff;
   logic [mqchi2_pkg::RACC_W-1:0]        racc_in, racc_ff;
   logic [mqchi2_pkg::SUM_W-1:0]         total_in, total_ff;
   logic [mqchi2_pkg::CHI_W-1:0]         sat;
   logic [mqchi2_pkg::CHI_W-1:0]         chi2_ff;
   logic                                 fits;

   always_comb begin
      if (s1_rowmul_ff) begin
         if (s1_k_ff == mqchi2_pkg::CHUNK_IDX_W'(mqchi2_pkg::NUM_CHUNKS - 1)) begin
            op_a = mqchi2_pkg::MUL_W'($signed(
                      racc_ff[mqchi2_pkg::RACC_W-1:2*mqchi2_pkg::CHUNK_W]));
         end else begin
            op_a = mqchi2_pkg::MUL_W'(mqchi2_pkg::CHUNK_W'(
                      racc_ff >> (mqchi2_pkg::CHUNK_W * s1_k_ff)));
         end
         op_b = mqchi2_pkg::MUL_W'(d_row);
      end else begin
         op_a = mqchi2_pkg::MUL_W'(d_col);
         op_b = mqchi2_pkg::MUL_W'(m_entry);
      end
      prod_in = op_a * op_b;
   end

   always_comb begin
      racc_in = racc_ff;
      if (p_scan_ff) begin
         racc_in = (p_first_ff ? '0 : racc_ff)
                 + (p_mask_ff ? mqchi2_pkg::RACC_W'(prod_ff) : '0);
      end
      total_in = total_ff;
      if (ctl.clear_total) begin
         total_in = '0;
      end else if (p_rowmul_ff && p_mask_ff) begin
         total_in = total_ff + (mqchi2_pkg::SUM_W'(prod_ff)
                                << (mqchi2_pkg::CHUNK_W * p_k_ff));
      end
   end

   always_comb begin
      fits = (&total_ff[mqchi2_pkg::SUM_W-1:mqchi2_pkg::FRAC_SHIFT+mqchi2_pkg::CHI_W-1])
          || (~|total_ff[mqchi2_pkg::SUM_W-1:mqchi2_pkg::FRAC_SHIFT+mqchi2_pkg::CHI_W-1]);
      if (fits) begin
         sat = total_ff[mqchi2_pkg::FRAC_SHIFT+mqchi2_pkg::CHI_W-1:mqchi2_pkg::FRAC_SHIFT];
      end else begin
         sat = total_ff[mqchi2_pkg::SUM_W-1] ? mqchi2_pkg::CHI_MIN : mqchi2_pkg::CHI_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_scan_ff   <= 1'b0;
         s1_rowmul_ff <= 1'b0;
         p_scan_ff    <= 1'b0;
         p_rowmul_ff  <= 1'b0;
      end else begin
         s1_scan_ff   <= ctl.scan_vld;
         s1_rowmul_ff <= ctl.rowmul_vld;
         p_scan_ff    <= s1_scan_ff;
         p_rowmul_ff  <= s1_rowmul_ff;
      end
      s1_first_ff <= ctl.first;
      s1_mask_ff  <= ctl.mask;
      s1_k_ff     <= ctl.k;
      p_first_ff  <= s1_first_ff;
      p_mask_ff   <= s1_mask_ff;
      p_k_ff      <= s1_k_ff;
      prod_ff     <= prod_in;
      racc_ff     <= racc_in;
      total_ff    <= total_in;
      if (ctl.emit) begin
         chi2_ff <= ctl.emit_zero ? '0 : sat;
      end
   end

   assign chi2 = chi2_ff;

endmodule

FILE: hw/rtl/mqchi2_seq.sv
// Sequencer that walks rows and columns and drives the shared multiply-accumulate unit.
module mqchi2_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  mqchi2_pkg::op_type                  req_op,
   input  logic                                set_enabled,
   input  logic [mqchi2_pkg::NUMP_W-1:0]       num_params,
   input  logic                                matrix_loaded,
   input  logic [mqchi2_pkg::MAX_PARAMS-1:0]   enable_vec,
   output logic                                busy,
   output logic                                rsp_valid,
   output logic                                rsp_status,
   output mqchi2_pkg::mac_ctl_type             ctl,
   output mqchi2_pkg::rd_idx_type              rd_idx
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_GAP,
      S_ROWMUL,
      S_FIN
   } state_type;

   state_type                          state_in, state_ff;
   logic [mqchi2_pkg::PIDX_W-1:0]      i_in, i_ff, j_in, j_ff, nlast_in, nlast_ff;
   logic [mqchi2_pkg::CHUNK_IDX_W-1:0] k_in, k_ff;
   logic [mqchi2_pkg::WAIT_W-1:0]      wait_in, wait_ff;
   logic                               busy_in, busy_ff;
   logic                               rsp_valid_in, rsp_valid_ff;
   logic                               rsp_status_in, rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      wait_in       = wait_ff;
      nlast_in      = nlast_ff;
      busy_in       = busy_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      ctl           = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start && req_op == mqchi2_pkg::OP_COMPUTE) begin
               if (!set_enabled || !matrix_loaded || num_params == '0) begin
                  ctl.emit      = 1'b1;
                  ctl.emit_zero = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = set_enabled && !matrix_loaded;
               end else begin
                  ctl.clear_total = 1'b1;
                  state_in        = S_SCAN;
                  i_in            = '0;
                  j_in            = '0;
                  busy_in         = 1'b1;
                  if (int'(num_params) > mqchi2_pkg::MAX_PARAMS) begin
                     nlast_in = mqchi2_pkg::PIDX_W'(mqchi2_pkg::MAX_PARAMS - 1);
                  end else begin
                     nlast_in = mqchi2_pkg::PIDX_W'(num_params - mqchi2_pkg::NUMP_W'(1));
                  end
               end
            end
         end
         S_SCAN: begin
            ctl.scan_vld = 1'b1;
            ctl.first    = (j_ff == '0);
            ctl.mask     = enable_vec[i_ff] && enable_vec[j_ff];
            if (j_ff == nlast_ff) begin
               state_in = S_GAP;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         S_GAP: begin
            state_in = S_ROWMUL;
            k_in     = '0;
         end
         S_ROWMUL: begin
            ctl.rowmul_vld = 1'b1;
            ctl.k          = k_ff;
            ctl.mask       = enable_vec[i_ff];
            if (k_ff == mqchi2_pkg::CHUNK_IDX_W'(mqchi2_pkg::NUM_CHUNKS - 1)) begin
               if (i_ff == nlast_ff) begin
                  state_in = S_FIN;
                  wait_in  = '0;
               end else begin
                  state_in = S_SCAN;
                  i_in     = i_ff + 1'b1;
                  j_in     = '0;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_FIN: begin
            if (wait_ff == mqchi2_pkg::WAIT_W'(mqchi2_pkg::FIN_WAIT)) begin
               ctl.emit      = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = 1'b0;
               busy_in       = 1'b0;
               state_in      = S_IDLE;
            end else begin
               wait_in = wait_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff          <= i_in;
      j_ff          <= j_in;
      k_ff          <= k_in;
      wait_ff       <= wait_in;
      nlast_ff      <= nlast_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy       = busy_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rd_idx.row = i_ff;
   assign rd_idx.col = j_ff;

endmodule

FILE: hw/rtl/mqchi2_checker.sv
// Port-level checker for the chi-square engine, bound to the top level.
module mqchi2_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input mqchi2_pkg::req_type req_item,
   input logic                rsp_valid,
   input mqchi2_pkg::rsp_type rsp_item
);

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_busy_from_compute: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(busy)) |->
         $past(start && !busy && req_item.op == mqchi2_pkg::OP_COMPUTE))
      else $error("busy without an accepted compute request");

   a_busy_ends_in_result: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_valid)
      else $error("compute finished without a result");

   a_status_zero_chi2: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status) |-> rsp_item.chi2 == '0)
      else $error("nonzero chi2 with status set");

   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && rsp_valid) |->
         ($past(busy) || $past(start && req_item.op == mqchi2_pkg::OP_COMPUTE)))
      else $error("result without a compute request");

endmodule

bind masked_quadratic_form_chi2_top mqchi2_checker u_mqchi2_checker (.*);

FILE: verif/tb_top.sv
// Self-checking testbench for the masked quadratic-form chi-square engine.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 4;
   localparam int MAX_GAP       = 40;
   localparam int NUM_PHASES    = 12;
   localparam int PHASE_ITEMS   = 8;
   localparam int LOAD_DIM      = 4;

   localparam logic [1:0] OP_RESERVED = 2'd3;

   localparam logic signed [127:0] Q32_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [127:0] Q32_MIN = -128'sh8000_0000_0000_0000;

   logic                              clock     = 1'b0;
   logic                              reset     = 1'b1;
   logic                              start     = 1'b0;
   logic                              busy;
   mqchi2_pkg::req_type               req_item  = '0;
   logic                              rsp_valid;
   mqchi2_pkg::rsp_type               rsp_item;
   logic                              csr_we    = 1'b0;
   logic [mqchi2_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [mqchi2_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   logic signed [31:0] inv_mat   [mqchi2_pkg::MAX_PARAMS][mqchi2_pkg::MAX_PARAMS];
   logic signed [31:0] par_value [mqchi2_pkg::MAX_PARAMS];
   logic signed [31:0] par_prior [mqchi2_pkg::MAX_PARAMS];
   logic               par_on    [mqchi2_pkg::MAX_PARAMS];
   logic               mat_loaded;
   logic               set_on;
   logic [mqchi2_pkg::NUMP_W-1:0] dim_reg;

   mqchi2_pkg::rsp_type chi2_expected [$];
   mqchi2_pkg::rsp_type chi2_want;
   int      errors       = 0;
   int      stall_cycles = 0;
   int      idle_pct     = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   masked_quadratic_form_chi2_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   function automatic mqchi2_pkg::rsp_type chi2_of_set();
      mqchi2_pkg::rsp_type res;
      logic signed [127:0] acc;
      logic signed [127:0] di;
      logic signed [127:0] dj;
      logic signed [127:0] q;
      int                  n;
      res = '0;
      if (!set_on) return res;
      if (!mat_loaded) begin
         res.status = 1'b1;
         return res;
      end
      n = (dim_reg > mqchi2_pkg::MAX_PARAMS) ? mqchi2_pkg::MAX_PARAMS : int'(dim_reg);
      acc = '0;
      for (int i = 0; i < n; i++) begin
         if (!par_on[i]) continue;
         di = par_value[i] - par_prior[i];
         for (int j = 0; j < n; j++) begin
            if (!par_on[j]) continue;
            dj = par_value[j] - par_prior[j];
            acc += di * dj * inv_mat[i][j];
         end
      end
      q = acc >>> mqchi2_pkg::FRAC_SHIFT;
      if (q > Q32_MAX) res.chi2 = mqchi2_pkg::CHI_MAX;
      else if (q < Q32_MIN) res.chi2 = mqchi2_pkg::CHI_MIN;
      else res.chi2 = q[63:0];
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (par_on[i]) par_on[i] = 1'b0;
         mat_loaded = 1'b0;
         set_on     = 1'b1;
         dim_reg    = mqchi2_pkg::NUMP_W'(mqchi2_pkg::NUMP_RESET);
      end else begin
         if (rsp_valid) begin
            if (chi2_expected.size() == 0) begin
               $error("unexpected result: chi2 %0d status %0d", rsp_item.chi2, rsp_item.status);
               errors++;
            end else begin
               chi2_want = chi2_expected.pop_front();
               if (rsp_item.chi2 !== chi2_want.chi2) begin
                  $error("chi2 mismatch: expected %0d, actual %0d", chi2_want.chi2, rsp_item.chi2);
                  errors++;
               end
               if (rsp_item.status !== chi2_want.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         chi2_want.status, rsp_item.status);
                  errors++;
               end
            end
         end
         if (start && !busy) begin
            case (req_item.op)
               mqchi2_pkg::OP_MATRIX: begin
                  inv_mat[req_item.row][req_item.col] = req_item.entry_value;
                  mat_loaded = 1'b1;
               end
               mqchi2_pkg::OP_PARAM: begin
                  par_value[req_item.row] = req_item.entry_value;
                  par_prior[req_item.row] = req_item.prior;
                  par_on[req_item.row]    = req_item.param_on;
               end
               mqchi2_pkg::OP_COMPUTE: chi2_expected.push_back(chi2_of_set());
               default: ;
            endcase
         end
         if (csr_we) begin
            if (csr_index == mqchi2_pkg::CSR_SET_ENABLED) set_on = csr_wdata[0];
            else dim_reg = csr_wdata[mqchi2_pkg::NUMP_W-1:0];
         end
         if (rsp_valid || (start && !busy) || csr_we) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   function automatic logic [31:0] rand_q16();
      case ($urandom_range(3))
         0: return $urandom();
         1: return $urandom_range(32'h7_FFFF) - 32'h4_0000;
         2: begin
            case ($urandom_range(4))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return 32'h0;
               3:       return 32'h1;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return 32'h1_0000 + $urandom_range(255) - 128;
      endcase
   endfunction

   function automatic mqchi2_pkg::req_type req_of(input mqchi2_pkg::op_type op, input int row,
                                                  input int col, input logic [31:0] value,
                                                  input logic [31:0] prior, input logic on);
      mqchi2_pkg::req_type r;
      r.op          = op;
      r.row         = 6'(row);
      r.col         = 6'(col);
      r.entry_value = value;
      r.prior       = prior;
      r.param_on    = on;
      return r;
   endfunction

   function automatic mqchi2_pkg::req_type compute_req();
      return req_of(mqchi2_pkg::OP_COMPUTE, $urandom_range(63), $urandom_range(63), $urandom(),
                    $urandom(), 1'($urandom_range(1)));
   endfunction

   function automatic int pick_index(input int dim);
      int lim;
      lim = (dim > mqchi2_pkg::MAX_PARAMS) ? mqchi2_pkg::MAX_PARAMS : dim;
      if (lim > 0 && $urandom_range(3) != 0) return $urandom_range(lim - 1);
      return $urandom_range(mqchi2_pkg::MAX_PARAMS - 1);
   endfunction

   task automatic send_request(input mqchi2_pkg::req_type r);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (chi2_expected.size() != 0 || busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input mqchi2_pkg::csr_index_type idx, input int value);
      settle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= mqchi2_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic test_unloaded_matrix();
      idle_pct = 35;
      send_request(compute_req());
      send_request(req_of(mqchi2_pkg::OP_PARAM, 0, 0, 32'h1_0000, 32'h0, 1'b1));
      send_request(req_of(mqchi2_pkg::op_type'(OP_RESERVED), $urandom_range(63),
                          $urandom_range(63), $urandom(), $urandom(), 1'($urandom_range(1))));
      send_request(compute_req());
      write_csr(mqchi2_pkg::CSR_SET_ENABLED, 0);
      send_request(compute_req());
      write_csr(mqchi2_pkg::CSR_SET_ENABLED, 1);
   endtask

   task automatic load_all_state();
      idle_pct = 0;
      for (int r = 0; r < LOAD_DIM; r++)
         send_request(req_of(mqchi2_pkg::OP_PARAM, r, $urandom_range(63), rand_q16(),
                             rand_q16(), 1'($urandom_range(1))));
      for (int r = 0; r < LOAD_DIM; r++)
         for (int c = 0; c < LOAD_DIM; c++)
            send_request(req_of(mqchi2_pkg::OP_MATRIX, r, c, rand_q16(), $urandom(),
                                1'($urandom_range(1))));
   endtask

   task automatic test_corner_cases();
      idle_pct = 35;
      write_csr(mqchi2_pkg::CSR_NUM_PARAMS, 1);
      send_request(req_of(mqchi2_pkg::OP_PARAM, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
      send_request(req_of(mqchi2_pkg::OP_MATRIX, 0, 0, 32'h7FFF_FFFF, 32'h0, 1'b0));
      send_request(compute_req());
      send_request(req_of(mqchi2_pkg::OP_MATRIX, 0, 0, 32'h8000_0000, 32'h0, 1'b0));
      send_request(compute_req());
      send_request(req_of(mqchi2_pkg::OP_PARAM, 0, 0, 32'h1, 32'h0, 1'b1));
      send_request(req_of(mqchi2_pkg::OP_MATRIX, 0, 0, 32'hFFFF_FFFF, 32'h0, 1'b0));
      send_request(compute_req());
      send_request(req_of(mqchi2_pkg::OP_PARAM, 0, 0, 32'h1, 32'h0, 1'b0));
      send_request(compute_req());
      write_csr(mqchi2_pkg::CSR_SET_ENABLED, 0);
      send_request(compute_req());
      write_csr(mqchi2_pkg::CSR_SET_ENABLED, 1);
      write_csr(mqchi2_pkg::CSR_NUM_PARAMS, 0);
      send_request(compute_req());
      write_csr(mqchi2_pkg::CSR_NUM_PARAMS, 127);
      send_request(compute_req());
      write_csr(mqchi2_pkg::CSR_NUM_PARAMS, mqchi2_pkg::MAX_PARAMS);
      send_request(compute_req());
   endtask

   task automatic test_random_traffic();
      int idle_choices [3] = '{0, 78, 35};
      int dim;
      int r;
      int c;
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_csr(mqchi2_pkg::CSR_SET_ENABLED, int'($urandom_range(5) != 0));
         case ($urandom_range(7))
            0:       dim = 0;
            1:       dim = $urandom_range(1) ? mqchi2_pkg::MAX_PARAMS : 127;
            default: dim = $urandom_range(1, 8);
         endcase
         write_csr(mqchi2_pkg::CSR_NUM_PARAMS, dim);
         idle_pct = idle_choices[p % 3];
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            r = pick_index(dim);
            c = pick_index(dim);
            case ($urandom_range(9))
               0, 1, 2: send_request(req_of(mqchi2_pkg::OP_MATRIX, r, c, rand_q16(), $urandom(),
                                            1'($urandom_range(1))));
               3, 4, 5: send_request(req_of(mqchi2_pkg::OP_PARAM, r, c, rand_q16(), rand_q16(),
                                            r < LOAD_DIM && $urandom_range(3) != 0));
               6, 7, 8: send_request(compute_req());
               default: send_request(req_of(mqchi2_pkg::op_type'(OP_RESERVED), r, c, $urandom(),
                                            $urandom(), 1'($urandom_range(1))));
            endcase
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_unloaded_matrix();
      load_all_state();
      test_corner_cases();
      test_random_traffic();
      settle();
      repeat (20) @(posedge clock);
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
